// ===== rtl/variable_length_message_ring_unit_assert.svh =====
// Assertion macros for the message ring unit.
// Used by the top level; depends on nothing else.
`ifndef VARIABLE_LENGTH_MESSAGE_RING_UNIT_ASSERT_SVH
`define VARIABLE_LENGTH_MESSAGE_RING_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define VMR_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define VMR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define VMR_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define VMR_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// ===== rtl/vmr_pkg.sv =====
// Shared types and constants for the message ring unit.
// No dependencies.
`default_nettype none
package vmr_pkg;
  localparam int CAPACITY_BYTES = 4096;
  localparam int STORE_DEPTH = CAPACITY_BYTES + 4;
  localparam int AW = $clog2(STORE_DEPTH);
  localparam int OW = $clog2(CAPACITY_BYTES);

  localparam logic [2:0] REQ_RESERVE = 3'd0;
  localparam logic [2:0] REQ_WRITE = 3'd1;
  localparam logic [2:0] REQ_COMMIT = 3'd2;
  localparam logic [2:0] REQ_ACQUIRE = 3'd3;
  localparam logic [2:0] REQ_READ = 3'd4;
  localparam logic [2:0] REQ_RELEASE = 3'd5;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_FAIL = 2'd1;
  localparam logic [1:0] ST_ORDER = 2'd2;

  localparam logic [31:0] WRAP_MARK = 32'hFFFF_FFFF;

  // datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_NONE    = 4'd0,
    OP_LATCH   = 4'd1,  // capture request, evaluate reserve
    OP_WMARK   = 4'd2,  // write one byte of wrap marker
    OP_WHDR    = 4'd3,  // write one byte of header
    OP_RSV_DONE = 4'd4,
    OP_WBYTE   = 4'd5,
    OP_RBYTE   = 4'd6,  // issue byte read
    OP_RBYTE_DONE = 4'd7,
    OP_COMMIT  = 4'd8,
    OP_HRD     = 4'd9,  // issue header byte read
    OP_HCAP    = 4'd10, // capture header byte
    OP_ACQ_EVAL = 4'd11,
    OP_RELEASE = 4'd12,
    OP_FAIL    = 4'd13,
    OP_ACQ_WRAP = 4'd14
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [1:0] idx;
  } cmd_t;

  typedef struct packed {
    logic [2:0] req;
    logic       rsv_ok;
    logic       rsv_wrap;
    logic       addr_ok;
    logic       empty;
    logic       is_mark;
    logic       mark_last;
  } stat_t;
endpackage
`default_nettype wire

// ===== rtl/variable_length_message_ring_unit.sv =====
// Top level of the variable-length message ring unit.
// Depends on vmr_pkg, vmr_ctrl, vmr_datapath, vmr_ram and the assertion header.
//
//  channel   | handshake              | fields
//  request   | start & !busy          | req_type size addr data_byte old_head end_head
//  result    | done (one cycle)       | status payload_addr msg_length token_* read_data
//
// Sequencing: reserve writes the wrap marker (when one is needed) and then the header
// into the store a byte at a time, read byte waits on the registered read, and acquire
// reads the header a byte at a time, again after a wrap marker unless it ends the data;
// the store's single write port and single read port set this byte-wise order.
// Reset: rst clears the heads and the controller; the byte store holds no reset.
// Stalls: the receiver cannot stall; done pulses for one cycle with the result.
`default_nettype none
`include "variable_length_message_ring_unit_assert.svh"
module variable_length_message_ring_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  output logic             done,
  input  wire logic [2:0]  req_type,
  input  wire logic [12:0] size,
  input  wire logic [12:0] addr,
  input  wire logic [7:0]  data_byte,
  input  wire logic [63:0] old_head,
  input  wire logic [63:0] end_head,
  output logic [1:0]       status,
  output logic [12:0]      payload_addr,
  output logic [12:0]      msg_length,
  output logic [63:0]      token_old_head,
  output logic [63:0]      token_new_head,
  output logic [7:0]       read_data
);
  vmr_pkg::cmd_t  cmd;
  vmr_pkg::stat_t stat;

  // sequence each transaction through the datapath
  vmr_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .stat(stat), .cmd(cmd),
    .busy(busy), .done(done)
  );

  // hold heads, store and result registers
  vmr_datapath u_dp (
    .clk(clk), .rst(rst), .req_type(req_type), .size(size), .addr(addr),
    .data_byte(data_byte), .old_head(old_head), .end_head(end_head),
    .cmd(cmd), .stat(stat), .status(status), .payload_addr(payload_addr),
    .msg_length(msg_length), .token_old_head(token_old_head),
    .token_new_head(token_new_head), .read_data(read_data)
  );

  `VMR_ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy, "accepted transaction not busy")
  `VMR_ASSERT_IMPL(a_done_busy, clk, rst, done, busy, "result outside transaction")
  `VMR_ASSERT_IMPL(a_status_range, clk, rst, done, status != 2'd3, "bad status code")
endmodule
`default_nettype wire

// ===== rtl/vmr_ram.sv =====
// Generic byte RAM with one write port and one registered read port.
// No dependencies.
`default_nettype none
module vmr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== rtl/vmr_datapath.sv =====
// Datapath: head registers, request latch, byte store and result registers.
// Depends on vmr_pkg and vmr_ram.
`default_nettype none
module vmr_datapath (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic [2:0]               req_type,
  input  wire logic [12:0]              size,
  input  wire logic [12:0]              addr,
  input  wire logic [7:0]               data_byte,
  input  wire logic [63:0]              old_head,
  input  wire logic [63:0]              end_head,
  input  wire vmr_pkg::cmd_t            cmd,
  output vmr_pkg::stat_t                stat,
  output logic [1:0]                    status,
  output logic [12:0]                   payload_addr,
  output logic [12:0]                   msg_length,
  output logic [63:0]                   token_old_head,
  output logic [63:0]                   token_new_head,
  output logic [7:0]                    read_data
);
  logic [63:0] producer_head, producer_tail, consumer_head;
  logic [2:0]  r_req;
  logic [12:0] r_size, r_addr;
  logic [7:0]  r_byte;
  logic [63:0] r_old, r_new;
  logic [63:0] nh;
  logic [12:0] mark_off, hdr_off;
  logic        rsv_ok, rsv_wrap;
  logic [31:0] hword;
  logic [31:0] size_word;
  logic [63:0] base;
  logic [12:0] acq_hdr;

  logic                 we;
  logic [vmr_pkg::AW-1:0] waddr, raddr;
  logic [7:0]           wdata, rdata;

  vmr_ram #(.WIDTH(8), .DEPTH(vmr_pkg::STORE_DEPTH)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  // reserve slot placement on live inputs; the overrun check follows from registers
  logic [63:0] off_c, to_end_c, need_c, nh_c;
  logic        wrap_c;
  always_comb begin
    off_c = {{(64-vmr_pkg::OW){1'b0}}, producer_head[vmr_pkg::OW-1:0]};
    to_end_c = 64'(vmr_pkg::CAPACITY_BYTES) - off_c;
    need_c = 64'(size) + 64'd4;
    wrap_c = to_end_c < need_c;
    nh_c = producer_head + need_c + (wrap_c ? to_end_c : 64'd0);
  end

  always_comb begin
    rsv_ok = (r_size != 13'd0) && (r_size <= 13'(vmr_pkg::CAPACITY_BYTES - 4))
        && ((nh - consumer_head) <= 64'(vmr_pkg::CAPACITY_BYTES));
  end

  logic [12:0] c_off;
  assign c_off = {{(13-vmr_pkg::OW){1'b0}}, consumer_head[vmr_pkg::OW-1:0]};

  assign size_word = {19'd0, r_size};

  always_comb begin
    stat.req = r_req;
    stat.rsv_ok = rsv_ok;
    stat.rsv_wrap = rsv_wrap;
    stat.addr_ok = r_addr < 13'(vmr_pkg::STORE_DEPTH);
    stat.empty = consumer_head == producer_tail;
    stat.is_mark = hword == vmr_pkg::WRAP_MARK;
    stat.mark_last = (consumer_head + 64'(vmr_pkg::CAPACITY_BYTES) - 64'(c_off))
        == producer_tail;
  end

  always_comb begin
    we = 1'b0;
    waddr = r_addr[vmr_pkg::AW-1:0];
    wdata = r_byte;
    raddr = r_addr[vmr_pkg::AW-1:0];
    case (cmd.op)
      vmr_pkg::OP_WMARK: begin
        we = 1'b1;
        waddr = vmr_pkg::AW'(mark_off + 13'(cmd.idx));
        wdata = 8'hFF;
      end
      vmr_pkg::OP_WHDR: begin
        we = 1'b1;
        waddr = vmr_pkg::AW'(hdr_off + 13'(cmd.idx));
        wdata = size_word[8*cmd.idx +: 8];
      end
      vmr_pkg::OP_WBYTE: we = 1'b1;
      vmr_pkg::OP_HRD: raddr = vmr_pkg::AW'(acq_hdr + 13'(cmd.idx));
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      producer_head <= '0;
      producer_tail <= '0;
      consumer_head <= '0;
    end else begin
      case (cmd.op)
        vmr_pkg::OP_RSV_DONE: producer_head <= nh;
        vmr_pkg::OP_COMMIT: if (producer_tail == r_old) producer_tail <= r_new;
        vmr_pkg::OP_RELEASE: consumer_head <= r_new;
        vmr_pkg::OP_ACQ_WRAP:
          if (stat.mark_last)
            consumer_head <= consumer_head + 64'(vmr_pkg::CAPACITY_BYTES) - 64'(c_off);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      vmr_pkg::OP_LATCH: begin
        r_req <= req_type; r_size <= size; r_addr <= addr; r_byte <= data_byte;
        r_old <= old_head; r_new <= end_head;
        nh <= nh_c; rsv_wrap <= wrap_c;
        mark_off <= 13'(off_c);
        hdr_off <= wrap_c ? 13'd0 : 13'(off_c);
        acq_hdr <= c_off;
        base <= consumer_head;
        hword <= '0;
        status <= vmr_pkg::ST_FAIL; payload_addr <= '0; msg_length <= '0;
        token_old_head <= '0; token_new_head <= '0; read_data <= '0;
      end
      vmr_pkg::OP_HCAP: hword[8*cmd.idx +: 8] <= rdata;
      vmr_pkg::OP_ACQ_WRAP: begin
        base <= consumer_head + 64'(vmr_pkg::CAPACITY_BYTES) - 64'(c_off);
        acq_hdr <= '0;
        hword <= '0;
      end
      vmr_pkg::OP_RSV_DONE: begin
        status <= vmr_pkg::ST_OK;
        payload_addr <= hdr_off + 13'd4;
        msg_length <= r_size;
        token_old_head <= producer_head;
        token_new_head <= nh;
      end
      vmr_pkg::OP_WBYTE: status <= vmr_pkg::ST_OK;
      vmr_pkg::OP_RBYTE_DONE: begin
        status <= vmr_pkg::ST_OK; read_data <= rdata;
      end
      vmr_pkg::OP_COMMIT:
        status <= (producer_tail == r_old) ? vmr_pkg::ST_OK : vmr_pkg::ST_ORDER;
      vmr_pkg::OP_RELEASE: status <= vmr_pkg::ST_OK;
      vmr_pkg::OP_ACQ_EVAL:
        if (hword != 32'd0 && hword <= 32'(vmr_pkg::CAPACITY_BYTES)) begin
          status <= vmr_pkg::ST_OK;
          payload_addr <= acq_hdr + 13'd4;
          msg_length <= hword[12:0];
          token_new_head <= base + 64'd4 + 64'(hword);
        end
      default: ;
    endcase
  end
endmodule
`default_nettype wire

// ===== rtl/vmr_ctrl.sv =====
// Controller state machine sequencing datapath operations.
// Depends on vmr_pkg.
`default_nettype none
module vmr_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  input  wire vmr_pkg::stat_t stat,
  output vmr_pkg::cmd_t       cmd,
  output logic                busy,
  output logic                done
);
  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_DISP   = 10'b0000000010,
    S_MARK   = 10'b0000000100,
    S_HDR    = 10'b0000001000,
    S_RD     = 10'b0000010000,
    S_HRD    = 10'b0000100000,
    S_HCAP   = 10'b0001000000,
    S_CHK    = 10'b0010000000,
    S_EVAL   = 10'b0100000000,
    S_FIN    = 10'b1000000000
  } state_t;

  state_t state, state_next;
  logic [1:0] idx, idx_next;
  logic       wrapped, wrapped_next;

  always_comb begin
    state_next = state;
    idx_next = idx;
    wrapped_next = wrapped;
    cmd.op = vmr_pkg::OP_NONE;
    cmd.idx = idx;
    done = 1'b0;
    case (state)
      S_IDLE: if (start) begin
        cmd.op = vmr_pkg::OP_LATCH;
        state_next = S_DISP;
      end
      S_DISP: begin
        idx_next = '0;
        wrapped_next = 1'b0;
        state_next = S_FIN;
        case (stat.req)
          vmr_pkg::REQ_RESERVE:
            if (stat.rsv_ok) state_next = stat.rsv_wrap ? S_MARK : S_HDR;
          vmr_pkg::REQ_WRITE: if (stat.addr_ok) cmd.op = vmr_pkg::OP_WBYTE;
          vmr_pkg::REQ_COMMIT: cmd.op = vmr_pkg::OP_COMMIT;
          vmr_pkg::REQ_ACQUIRE: if (!stat.empty) state_next = S_HRD;
          vmr_pkg::REQ_READ: if (stat.addr_ok) begin
            cmd.op = vmr_pkg::OP_RBYTE;
            state_next = S_RD;
          end
          vmr_pkg::REQ_RELEASE: cmd.op = vmr_pkg::OP_RELEASE;
          default: ;
        endcase
      end
      S_MARK: begin
        cmd.op = vmr_pkg::OP_WMARK;
        idx_next = idx + 2'd1;
        if (idx == 2'd3) state_next = S_HDR;
      end
      S_HDR: begin
        cmd.op = vmr_pkg::OP_WHDR;
        idx_next = idx + 2'd1;
        if (idx == 2'd3) state_next = S_EVAL;
      end
      S_EVAL: begin
        cmd.op = vmr_pkg::OP_RSV_DONE;
        state_next = S_FIN;
      end
      S_RD: begin
        cmd.op = vmr_pkg::OP_RBYTE_DONE;
        state_next = S_FIN;
      end
      S_HRD: begin
        cmd.op = vmr_pkg::OP_HRD;
        state_next = S_HCAP;
      end
      S_HCAP: begin
        cmd.op = vmr_pkg::OP_HCAP;
        idx_next = idx + 2'd1;
        state_next = (idx == 2'd3) ? S_CHK : S_HRD;
      end
      S_CHK: begin
        idx_next = '0;
        if (stat.is_mark && !wrapped) begin
          cmd.op = vmr_pkg::OP_ACQ_WRAP;
          wrapped_next = 1'b1;
          state_next = stat.mark_last ? S_FIN : S_HRD;
        end else begin
          cmd.op = vmr_pkg::OP_ACQ_EVAL;
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        done = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign busy = state != S_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx <= '0;
      wrapped <= 1'b0;
    end else begin
      state <= state_next;
      idx <= idx_next;
      wrapped <= wrapped_next;
    end
  end
endmodule
`default_nettype wire
